>>> rtl/dstrm_pkg.sv
`default_nettype none
package dstrm_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int LEAF_W = $clog2(MAX_ELEMENTS);
    localparam int NODE_W = LEAF_W + 1;
    localparam int SIZE_W = 11;
    localparam int DATA_W = 32;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [NODE_W-1:0] TREE_CLR_LAST = {NODE_W{1'b1}};

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic CFG_SIZE_FIRST = 1'b0;
    localparam logic CFG_SIZE_SECOND = 1'b1;

    typedef struct packed {
        logic        clr;
        logic        upd_start;
        logic        qry_start;
        logic [1:0]  qry_phase;
    } t_dp_cmd;

    typedef struct packed {
        logic upd_done;
        logic qry_done;
    } t_dp_sts;

    function automatic logic smin_sel(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        return $signed(a) <= $signed(b);
    endfunction

    function automatic logic [DATA_W-1:0] smin(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
        return smin_sel(a, b) ? a : b;
    endfunction

    function automatic logic [LEAF_W:0] eff_size(input logic [SIZE_W-1:0] sz);
        return (sz > SIZE_W'(MAX_ELEMENTS)) ? (LEAF_W+1)'(MAX_ELEMENTS) : (LEAF_W+1)'(sz);
    endfunction
endpackage
`default_nettype wire

>>> rtl/dstrm_ram.sv
`default_nettype none
module dstrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/dstrm_tree.sv
`default_nettype none
// One tree: clear walk, update walk (read sibling, write parent) and a query walk.
// Query walk per level: read lo node, then hi-1 node, fold, halve.
module dstrm_tree
    import dstrm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_upd_en,
    input  wire logic [LEAF_W-1:0] i_pos,
    input  wire logic [DATA_W-1:0] i_val,
    input  wire logic [SIZE_W-1:0] i_size,
    input  wire logic [LEAF_W-1:0] i_left,
    input  wire logic [LEAF_W-1:0] i_right,
    output      logic              o_upd_done,
    output      logic              o_qry_done,
    output      logic [DATA_W-1:0] o_res
);
    localparam logic [2:0] S_IDLE = 3'd0, S_CLR = 3'd1, S_URD = 3'd2, S_UWT = 3'd3,
                           S_QCHK = 3'd4, S_QLO = 3'd5, S_QHI = 3'd6, S_QWT = 3'd7;

    logic [2:0]        r_st, n_st;
    logic [NODE_W-1:0] r_p, n_p;
    logic [DATA_W-1:0] r_cur, n_cur;
    logic [NODE_W:0]   r_lo, n_lo, r_hi, n_hi;
    logic [DATA_W-1:0] r_res, n_res;
    logic              r_lopend, n_lopend;
    logic              r_hipend, n_hipend;

    logic              we;
    logic [NODE_W-1:0] waddr, raddr;
    logic [DATA_W-1:0] wdata, rdata;

    logic [LEAF_W:0] n_eff;
    logic [LEAF_W:0] rclip;

    dstrm_ram #(.WIDTH(DATA_W), .DEPTH(2*MAX_ELEMENTS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        n_eff = eff_size(i_size);
        rclip = ({1'b0, i_right} > n_eff - 1'b1) ? n_eff - 1'b1 : {1'b0, i_right};
    end

    always_comb begin
        n_st = r_st; n_p = r_p; n_cur = r_cur; n_lo = r_lo; n_hi = r_hi;
        n_res = r_res; n_lopend = r_lopend; n_hipend = r_hipend;
        we = 1'b0; waddr = r_p; wdata = r_cur; raddr = r_p ^ NODE_W'(1);
        o_upd_done = 1'b0; o_qry_done = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (i_cmd.clr) begin
                    n_st = S_CLR; n_p = '0;
                end else if (i_cmd.upd_start) begin
                    if (i_upd_en && ({1'b0, i_pos} < n_eff)) begin
                        we = 1'b1;
                        waddr = NODE_W'(MAX_ELEMENTS) + NODE_W'(i_pos);
                        wdata = i_val;
                        n_p = NODE_W'(MAX_ELEMENTS) + NODE_W'(i_pos);
                        n_cur = i_val;
                        n_st = S_URD;
                    end else begin
                        o_upd_done = 1'b1;
                    end
                end else if (i_cmd.qry_start) begin
                    n_res = INT_MAX;
                    n_lo = (NODE_W+1)'(MAX_ELEMENTS) + (NODE_W+1)'(i_left);
                    n_hi = (NODE_W+1)'(MAX_ELEMENTS) + (NODE_W+1)'(rclip) + 1'b1;
                    if (n_eff == '0 || {1'b0, i_left} > rclip) begin
                        n_hi = n_lo;
                    end
                    n_st = S_QCHK;
                end
            end
            S_CLR: begin
                we = 1'b1; waddr = r_p; wdata = INT_MAX;
                n_p = r_p + 1'b1;
                if (r_p == TREE_CLR_LAST) n_st = S_IDLE;
            end
            S_URD: begin
                raddr = r_p ^ NODE_W'(1);
                n_st = S_UWT;
            end
            S_UWT: begin
                we = 1'b1;
                waddr = r_p >> 1;
                wdata = smin(r_cur, rdata);
                n_cur = smin(r_cur, rdata);
                n_p = r_p >> 1;
                if ((r_p >> 1) == NODE_W'(1)) begin
                    n_st = S_IDLE; o_upd_done = 1'b1;
                end else begin
                    n_st = S_URD;
                end
            end
            S_QCHK: begin
                if (r_lo >= r_hi) begin
                    o_qry_done = 1'b1; n_st = S_IDLE;
                end else begin
                    n_lopend = r_lo[0];
                    n_hipend = r_hi[0];
                    raddr = NODE_W'(r_lo);
                    n_st = S_QLO;
                end
            end
            S_QLO: begin
                raddr = NODE_W'(r_hi - 1'b1);
                if (r_lopend) n_res = smin(r_res, rdata);
                n_st = S_QHI;
            end
            S_QHI: begin
                raddr = NODE_W'(r_hi - 1'b1);
                if (r_hipend) n_res = smin(r_res, rdata);
                n_lo = (r_lo + (NODE_W+1)'(r_lopend)) >> 1;
                n_hi = (r_hi - (NODE_W+1)'(r_hipend)) >> 1;
                n_st = S_QCHK;
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_p <= '0;
        end else begin
            r_st <= n_st;
            r_p <= n_p;
        end
        r_cur <= n_cur; r_lo <= n_lo; r_hi <= n_hi; r_res <= n_res;
        r_lopend <= n_lopend; r_hipend <= n_hipend;
    end

    assign o_res = r_res;
endmodule
`default_nettype wire

>>> rtl/dstrm_dp.sv
`default_nettype none
module dstrm_dp
    import dstrm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic              i_sel,
    input  wire logic [LEAF_W-1:0] i_pos,
    input  wire logic [DATA_W-1:0] i_val,
    input  wire logic [SIZE_W-1:0] i_size_a,
    input  wire logic [SIZE_W-1:0] i_size_b,
    input  wire logic [LEAF_W-1:0] i_la,
    input  wire logic [LEAF_W-1:0] i_ra,
    input  wire logic [LEAF_W-1:0] i_lb,
    input  wire logic [LEAF_W-1:0] i_rb,
    output      t_dp_sts           o_sts,
    output      logic [DATA_W-1:0] o_ma,
    output      logic [DATA_W-1:0] o_mb,
    output      logic [DATA_W-1:0] o_wa,
    output      logic [DATA_W-1:0] o_wb
);
    logic ua, ub, qa, qb;
    logic [DATA_W-1:0] ra, rb;
    logic r_ua, r_ub, r_qa, r_qb;
    logic [LEAF_W-1:0] l_a, r_a, l_b, r_b2;

    always_comb begin
        if (i_cmd.qry_phase == 2'd0) begin
            l_a = i_la; r_a = i_ra; l_b = i_lb; r_b2 = i_rb;
        end else begin
            l_a = '0; r_a = '1; l_b = '0; r_b2 = '1;
        end
    end

    dstrm_tree u_a (.i_clk, .i_rst_n, .i_cmd, .i_upd_en(i_sel == 1'b0), .i_pos, .i_val,
        .i_size(i_size_a), .i_left(l_a), .i_right(r_a),
        .o_upd_done(ua), .o_qry_done(qa), .o_res(ra));
    dstrm_tree u_b (.i_clk, .i_rst_n, .i_cmd, .i_upd_en(i_sel == 1'b1), .i_pos, .i_val,
        .i_size(i_size_b), .i_left(l_b), .i_right(r_b2),
        .o_upd_done(ub), .o_qry_done(qb), .o_res(rb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ua <= 1'b0; r_ub <= 1'b0; r_qa <= 1'b0; r_qb <= 1'b0;
        end else if (i_cmd.upd_start || i_cmd.qry_start) begin
            r_ua <= ua; r_ub <= ub; r_qa <= qa; r_qb <= qb;
        end else begin
            r_ua <= r_ua | ua; r_ub <= r_ub | ub;
            r_qa <= r_qa | qa; r_qb <= r_qb | qb;
        end
        if (qa && i_cmd.qry_phase == 2'd0) o_ma <= ra;
        if (qb && i_cmd.qry_phase == 2'd0) o_mb <= rb;
        if (qa && i_cmd.qry_phase == 2'd1) o_wa <= ra;
        if (qb && i_cmd.qry_phase == 2'd1) o_wb <= rb;
    end

    assign o_sts.upd_done = (r_ua | ua) & (r_ub | ub);
    assign o_sts.qry_done = r_qa & r_qb;
endmodule
`default_nettype wire

>>> rtl/dstrm_ctrl.sv
`default_nettype none
module dstrm_ctrl
    import dstrm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_beat,
    input  wire logic    i_cmd_q,
    input  wire logic    i_out_free,
    input  wire t_dp_sts i_sts,
    output      logic    o_ready,
    output      t_dp_cmd o_cmd,
    output      logic    o_load,
    output      logic    o_result
);
    localparam logic [2:0] C_CLR = 3'd0, C_IDLE = 3'd1, C_UPD = 3'd2, C_Q0 = 3'd3,
                           C_Q1S = 3'd4, C_Q1 = 3'd5, C_OUT = 3'd6;
    logic [2:0]        r_st, n_st;
    logic [NODE_W-1:0] r_cnt;

    always_comb begin
        n_st = r_st;
        o_cmd = '0;
        o_ready = 1'b0;
        o_load = 1'b0;
        o_result = 1'b0;
        unique case (r_st)
            C_CLR: begin
                if (r_cnt == TREE_CLR_LAST) n_st = C_IDLE;
            end
            C_IDLE: begin
                o_ready = 1'b1;
                if (i_in_beat) begin
                    o_load = 1'b1;
                    n_st = (i_cmd_q == CMD_QUERY) ? C_Q0 : C_UPD;
                end
            end
            C_UPD: begin
                o_cmd.upd_start = 1'b1;
                n_st = C_Q1S;
            end
            C_Q0: begin
                o_cmd.qry_start = 1'b1;
                n_st = C_Q1;
            end
            C_Q1S: begin
                if (i_sts.upd_done) n_st = C_IDLE;
            end
            C_Q1: begin
                if (i_sts.qry_done) begin
                    o_cmd.qry_start = 1'b1;
                    o_cmd.qry_phase = 2'd1;
                    n_st = C_OUT;
                end
            end
            C_OUT: begin
                o_cmd.qry_phase = 2'd1;
                if (i_sts.qry_done && i_out_free) begin
                    o_result = 1'b1;
                    n_st = C_IDLE;
                end
            end
            default: n_st = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_CLR;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            r_cnt <= r_cnt + 1'b1;
        end
    end
endmodule
`default_nettype wire

>>> rtl/dual_segment_tree_range_min_unit.sv
`default_nettype none
// Update: one sibling read and one parent write per level (leaf write first, root write last).
// Query: two tree walks (range, then whole array), each level a range check, a low-node read
// and a high-node read, plus a final check; then the result waits for a free output register.
// The two trees share no RAM port and walk in parallel; one item is in work at a time.
// Reset: synchronous, active low; after reset both trees write INT_MAX to every node,
// during which no beat is accepted. Sizes reset to 1024.
module dual_segment_tree_range_min_unit
    import dstrm_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output      logic          s_axis_tready,
    // command, array_select, position, new_value, left_first, right_first,
    // left_second, right_second
    input  wire logic [87:0]   s_axis_tdata,
    output      logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // min_first, min_second, min_overall, whole_min_first, whole_min_second
    output      logic [159:0]  m_axis_tdata,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);
    logic [87:0] r_in;
    logic [SIZE_W-1:0] r_size_a, r_size_b;
    logic in_beat, load, result, out_free;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic [DATA_W-1:0] ma, mb, wa, wb;

    assign in_beat = s_axis_tvalid & s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;

    dstrm_ctrl u_ctrl (.i_clk, .i_rst_n, .i_in_beat(in_beat), .i_cmd_q(s_axis_tdata[0]),
        .i_out_free(out_free), .i_sts(sts), .o_ready(s_axis_tready), .o_cmd(cmd),
        .o_load(load), .o_result(result));

    dstrm_dp u_dp (.i_clk, .i_rst_n, .i_cmd(cmd), .i_sel(r_in[1]), .i_pos(r_in[11:2]),
        .i_val(r_in[43:12]), .i_size_a(r_size_a), .i_size_b(r_size_b),
        .i_la(r_in[53:44]), .i_ra(r_in[63:54]), .i_lb(r_in[73:64]), .i_rb(r_in[83:74]),
        .o_sts(sts), .o_ma(ma), .o_mb(mb), .o_wa(wa), .o_wb(wb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_a <= SIZE_W'(1024);
            r_size_b <= SIZE_W'(1024);
            m_axis_tvalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_SIZE_FIRST) r_size_a <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == CFG_SIZE_SECOND) r_size_b <= i_cfg_data;
            if (result) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        if (load) r_in <= s_axis_tdata;
        if (result) m_axis_tdata <= {wb, wa, smin(ma, mb), mb, ma};
    end
endmodule
`default_nettype wire

>>> sim/tb_dual_segment_tree_range_min_unit.sv
`default_nettype none
module tb_dual_segment_tree_range_min_unit;
    import dstrm_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic        cmd;
        logic        sel;
        logic [9:0]  pos;
        logic [31:0] val;
        logic [9:0]  lf;
        logic [9:0]  rf;
        logic [9:0]  ls;
        logic [9:0]  rs;
    } t_item;

    typedef struct packed {
        logic [31:0] min_first;
        logic [31:0] min_second;
        logic [31:0] min_overall;
        logic [31:0] whole_first;
        logic [31:0] whole_second;
    } t_minima;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    // command, array_select, position, new_value, left_first, right_first,
    // left_second, right_second
    logic [87:0]   s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    // min_first, min_second, min_overall, whole_min_first, whole_min_second
    logic [159:0]  m_axis_tdata;
    logic          i_cfg_we;
    logic          i_cfg_idx;
    logic [SIZE_W-1:0] i_cfg_data;

    logic [31:0]   tree_a [2*MAX_ELEMENTS];
    logic [31:0]   tree_b [2*MAX_ELEMENTS];
    logic [SIZE_W-1:0] size_a;
    logic [SIZE_W-1:0] size_b;
    t_minima       minima_pending [$];
    int            errors;
    int            cycles;
    int            send_idle_pct;
    int            recv_stall_pct;

    dual_segment_tree_range_min_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [31:0] lesser(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a) <= $signed(b)) ? a : b;
    endfunction

    function automatic int clip_size(input logic [SIZE_W-1:0] sz);
        return (sz > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(sz);
    endfunction

    function automatic logic [31:0] range_minimum(input logic sel, input int l, input int r);
        int n;
        int lo;
        int hi;
        logic [31:0] acc;
        n = clip_size(sel ? size_b : size_a);
        acc = INT_MAX;
        if (n == 0)
            return acc;
        if (r > n - 1)
            r = n - 1;
        if (l > r)
            return acc;
        lo = l + MAX_ELEMENTS;
        hi = r + MAX_ELEMENTS + 1;
        while (lo < hi) begin
            if (lo[0]) begin
                acc = lesser(acc, sel ? tree_b[lo] : tree_a[lo]);
                lo++;
            end
            if (hi[0]) begin
                hi--;
                acc = lesser(acc, sel ? tree_b[hi] : tree_a[hi]);
            end
            lo = lo >> 1;
            hi = hi >> 1;
        end
        return acc;
    endfunction

    task automatic apply_item(input t_item it);
        int p;
        t_minima m;
        if (it.cmd == CMD_UPDATE) begin
            if (int'(it.pos) < clip_size(it.sel ? size_b : size_a)) begin
                p = MAX_ELEMENTS + int'(it.pos);
                if (it.sel) tree_b[p] = it.val;
                else tree_a[p] = it.val;
                while (p > 1) begin
                    p = p >> 1;
                    if (it.sel) tree_b[p] = lesser(tree_b[2*p], tree_b[2*p+1]);
                    else tree_a[p] = lesser(tree_a[2*p], tree_a[2*p+1]);
                end
            end
        end else begin
            m.min_first = range_minimum(1'b0, it.lf, it.rf);
            m.min_second = range_minimum(1'b1, it.ls, it.rs);
            m.min_overall = lesser(m.min_first, m.min_second);
            m.whole_first = range_minimum(1'b0, 0, MAX_ELEMENTS);
            m.whole_second = range_minimum(1'b1, 0, MAX_ELEMENTS);
            minima_pending.push_back(m);
        end
    endtask

    task automatic send_item(input t_item it);
        @(negedge i_clk);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, it.rs, it.ls, it.rf, it.lf, it.val, it.pos, it.sel, it.cmd};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_item(it);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (minima_pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size(input logic idx, input logic [SIZE_W-1:0] value);
        release_input();
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_SIZE_SECOND) size_b = value;
        else size_a = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_update(input logic sel, input int pos, input logic [31:0] val);
        t_item it;
        it = '0;
        it.cmd = CMD_UPDATE;
        it.sel = sel;
        it.pos = pos[9:0];
        it.val = val;
        send_item(it);
    endtask

    task automatic send_query(input int lf, input int rf, input int ls, input int rs);
        t_item it;
        it = '0;
        it.cmd = CMD_QUERY;
        it.lf = lf[9:0];
        it.rf = rf[9:0];
        it.ls = ls[9:0];
        it.rs = rs[9:0];
        send_item(it);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d want %0d", what, $signed(got), $signed(want));
        errors++;
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n)
            m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_minima got;
        t_minima want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
                   m_axis_tdata[127:96], m_axis_tdata[159:128]};
            if (minima_pending.size() == 0) begin
                report_mismatch("unexpected beat", got.min_first, INT_MAX);
            end else begin
                want = minima_pending.pop_front();
                if (got.min_first !== want.min_first)
                    report_mismatch("min_first", got.min_first, want.min_first);
                if (got.min_second !== want.min_second)
                    report_mismatch("min_second", got.min_second, want.min_second);
                if (got.min_overall !== want.min_overall)
                    report_mismatch("min_overall", got.min_overall, want.min_overall);
                if (got.whole_first !== want.whole_first)
                    report_mismatch("whole_min_first", got.whole_first, want.whole_first);
                if (got.whole_second !== want.whole_second)
                    report_mismatch("whole_min_second", got.whole_second,
                                    want.whole_second);
            end
        end
    end

    task automatic test_cleared_trees();
        send_query(0, 1023, 0, 1023);
        send_query(5, 3, 1023, 1023);
    endtask

    task automatic test_extremes();
        send_update(1'b0, 0, 32'h8000_0000);
        send_update(1'b0, 1023, 32'h7FFF_FFFF);
        send_update(1'b1, 1023, 32'hFFFF_FFFF);
        send_update(1'b1, 0, 32'h0000_0000);
        send_update(1'b0, 512, 32'h0000_0001);
        send_query(0, 0, 1023, 1023);
        send_query(1, 1023, 0, 1022);
        send_query(600, 100, 0, 0);
        send_query(512, 512, 1, 1022);
    endtask

    task automatic test_size_limits();
        write_size(CFG_SIZE_FIRST, 11'd1);
        write_size(CFG_SIZE_SECOND, 11'd0);
        send_update(1'b0, 1, 32'hDEAD_BEEF);
        send_update(1'b1, 0, 32'h8000_0000);
        send_query(0, 1023, 0, 1023);
        send_query(1, 1023, 5, 9);
        write_size(CFG_SIZE_FIRST, 11'd2047);
        write_size(CFG_SIZE_SECOND, 11'd1025);
        send_update(1'b1, 1023, 32'h8000_0000);
        send_query(0, 1023, 1000, 1023);
        write_size(CFG_SIZE_FIRST, 11'd300);
        write_size(CFG_SIZE_SECOND, 11'd600);
        send_update(1'b0, 300, 32'h8000_0000);
        send_update(1'b0, 299, 32'hFFFF_FF00);
        send_query(250, 1023, 600, 1023);
        send_query(300, 1023, 0, 599);
        release_input();
    endtask

    task automatic test_random(input int count);
        int i;
        int n;
        int a;
        int b;
        int c;
        int d;
        logic sel;
        for (i = 0; i < count; i++) begin
            if (i % 225 == 0) begin
                case ((i / 225) % 4)
                    0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                    1: begin send_idle_pct = 70; recv_stall_pct = 0; end
                    2: begin send_idle_pct = 0; recv_stall_pct = 70; end
                    default: begin send_idle_pct = 22; recv_stall_pct = 22; end
                endcase
                case ($urandom_range(5))
                    0: write_size(CFG_SIZE_FIRST, 11'($urandom_range(2047)));
                    1: write_size(CFG_SIZE_SECOND, 11'($urandom_range(1, 1024)));
                    2: write_size(CFG_SIZE_FIRST, 11'($urandom_range(1, 32)));
                    3: write_size(CFG_SIZE_SECOND, 11'($urandom_range(1, 32)));
                    4: write_size(CFG_SIZE_FIRST, 11'(MAX_ELEMENTS));
                    default: write_size(CFG_SIZE_SECOND, 11'($urandom_range(2047)));
                endcase
            end
            sel = 1'($urandom_range(1));
            n = clip_size(sel ? size_b : size_a);
            if ($urandom_range(99) < 55) begin
                if (n > 0 && $urandom_range(9) != 0) a = $urandom_range(n - 1);
                else a = $urandom_range(1023);
                case ($urandom_range(3))
                    0: send_update(sel, a, $urandom_range(200) - 100);
                    default: send_update(sel, a, $urandom);
                endcase
            end else begin
                a = $urandom_range(1023);
                b = $urandom_range(1023);
                c = $urandom_range(1023);
                d = $urandom_range(1023);
                if ($urandom_range(3) != 0) begin
                    if (a > b) begin n = a; a = b; b = n; end
                    if (c > d) begin n = c; c = d; d = n; end
                end
                send_query(a, b, c, d);
            end
        end
        release_input();
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SIZE_FIRST;
        i_cfg_data = '0;
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        size_a = 11'(MAX_ELEMENTS);
        size_b = 11'(MAX_ELEMENTS);
        for (int k = 0; k < 2*MAX_ELEMENTS; k++) begin
            tree_a[k] = INT_MAX;
            tree_b[k] = INT_MAX;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_trees();
        test_extremes();
        test_size_limits();
        test_random(1800);
        drain();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
rtl/dstrm_pkg.sv
rtl/dstrm_ram.sv
rtl/dstrm_tree.sv
rtl/dstrm_dp.sv
rtl/dstrm_ctrl.sv
rtl/dual_segment_tree_range_min_unit.sv
sim/tb_dual_segment_tree_range_min_unit.sv
